/* rtl/clebs_pkg.sv */
`timescale 1ns / 1ps

package clebs_pkg;

    // Request codes
    localparam logic [2:0] REQ_CMD_BYTE  = 3'd0;
    localparam logic [2:0] REQ_DATA_BYTE = 3'd1;
    localparam logic [2:0] REQ_CMD_NIB   = 3'd2;
    localparam logic [2:0] REQ_CURSOR    = 3'd3;
    localparam logic [2:0] REQ_NUMBER    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_BACKLIGHT = 3'd0;
    localparam logic [2:0] CFG_ENABLE    = 3'd1;
    localparam logic [2:0] CFG_SELECT    = 3'd2;
    localparam logic [2:0] CFG_ROW0_ADDR = 3'd3;
    localparam logic [2:0] CFG_ROW1_ADDR = 3'd4;

    localparam logic [7:0] RST_BACKLIGHT = 8'h08;
    localparam logic [7:0] RST_ENABLE    = 8'h04;
    localparam logic [7:0] RST_SELECT    = 8'h01;
    localparam logic [7:0] RST_ROW0_ADDR = 8'h80;
    localparam logic [7:0] RST_ROW1_ADDR = 8'hC0;

    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    localparam int NUMBER_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] backlight;
        logic [7:0] enable;
        logic [7:0] select;
        logic [7:0] row0_addr;
        logic [7:0] row1_addr;
    } t_cfg;

    // One byte transfer queued between the front and the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       nibble_only;
        logic       last;
    } t_job;

endpackage

/* rtl/clebs_front.sv */
`timescale 1ns / 1ps

module clebs_front #(
    parameter int NUMBER_BITS = clebs_pkg::NUMBER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_req_type,
    input  logic [31:0]       i_value,
    input  logic              i_row,
    input  logic [7:0]        i_col,
    input  clebs_pkg::t_cfg   i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output clebs_pkg::t_job   o_job
);

    localparam int DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int BIT_W  = $clog2(NUMBER_BITS + 1);
    localparam int DIG_W  = $clog2(DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [NUMBER_BITS-1:0]   r_num, n_num;
    logic [BCD_W-1:0]         r_bcd, n_bcd;
    logic [BIT_W-1:0]         r_bits, n_bits;
    logic [DIG_W-1:0]         r_left, n_left;
    logic [BCD_W-1:0]         bcd_adj;
    logic [3:0]               top_digit;
    logic                     accept;
    logic [7:0]               cursor_cmd;

    assign o_ready    = (r_state == ST_IDLE) && !i_full;
    assign accept     = i_valid && o_ready;
    assign top_digit  = r_bcd[BCD_W-1 -: 4];
    assign cursor_cmd = (i_row ? i_cfg.row1_addr : i_cfg.row0_addr) + i_col;

    // Add 3 to every BCD digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_bcd   = r_bcd;
        n_bits  = r_bits;
        n_left  = r_left;
        o_push  = 1'b0;
        o_job   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        clebs_pkg::REQ_CMD_BYTE: begin
                            o_push            = 1'b1;
                            o_job.data_byte   = i_value[7:0];
                            o_job.last        = 1'b1;
                        end
                        clebs_pkg::REQ_DATA_BYTE: begin
                            o_push            = 1'b1;
                            o_job.data_byte   = i_value[7:0];
                            o_job.is_data     = 1'b1;
                            o_job.last        = 1'b1;
                        end
                        clebs_pkg::REQ_CMD_NIB: begin
                            o_push            = 1'b1;
                            o_job.data_byte   = i_value[7:0];
                            o_job.nibble_only = 1'b1;
                            o_job.last        = 1'b1;
                        end
                        clebs_pkg::REQ_CURSOR: begin
                            o_push            = 1'b1;
                            o_job.data_byte   = cursor_cmd;
                            o_job.last        = 1'b1;
                        end
                        clebs_pkg::REQ_NUMBER: begin
                            n_num   = i_value[NUMBER_BITS-1:0];
                            n_bcd   = '0;
                            n_bits  = BIT_W'(NUMBER_BITS);
                            n_left  = DIG_W'(DIGITS);
                            n_state = ST_CONV;
                        end
                        default: ; // unused codes: drop
                    endcase
                end
            end
            ST_CONV: begin
                n_bcd  = {bcd_adj[BCD_W-2:0], r_num[NUMBER_BITS-1]};
                n_num  = r_num << 1;
                n_bits = r_bits - BIT_W'(1);
                if (r_bits == BIT_W'(1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // skip leading zeros, keep at least one digit
                if (top_digit == 4'd0 && r_left != DIG_W'(1)) begin
                    n_bcd  = r_bcd << 4;
                    n_left = r_left - DIG_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_full) begin
                    o_push          = 1'b1;
                    o_job.data_byte = clebs_pkg::ASCII_ZERO | {4'h0, top_digit};
                    o_job.is_data   = 1'b1;
                    o_job.last      = (r_left == DIG_W'(1));
                    n_bcd           = r_bcd << 4;
                    n_left          = r_left - DIG_W'(1);
                    if (r_left == DIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_num  <= n_num;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_left <= n_left;
    end

endmodule

/* rtl/clebs_queue.sv */
`timescale 1ns / 1ps

module clebs_queue #(
    parameter int DEPTH = clebs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clebs_pkg::t_job i_job,
    input  logic            i_pop,
    output clebs_pkg::t_job o_job,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clebs_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/clebs_back.sv */
`timescale 1ns / 1ps

module clebs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clebs_pkg::t_cfg i_cfg,
    input  clebs_pkg::t_job i_job,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_expander_byte,
    output logic            o_last_of_run
);

    clebs_pkg::t_job r_job;
    logic            r_busy;
    logic [1:0]      r_step;
    logic [7:0]      nib;
    logic [7:0]      base;
    logic            final_step;
    logic            out_accept;

    // step bit 1 picks the nibble, bit 0 drops the enable strobe
    assign nib        = r_step[1] ? {r_job.data_byte[3:0], 4'h0}
                                  : (r_job.data_byte & clebs_pkg::NIBBLE_MASK);
    assign base       = nib | i_cfg.backlight | (r_job.is_data ? i_cfg.select : 8'h00);
    assign final_step = r_job.nibble_only ? (r_step == 2'd1) : (r_step == 2'd3);
    assign out_accept = r_busy && i_ready;

    assign o_valid         = r_busy;
    assign o_expander_byte = r_step[0] ? base : (base | i_cfg.enable);
    assign o_last_of_run   = r_job.last && final_step;

    assign o_pop = !i_empty && (!r_busy || (out_accept && final_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
        end else if (out_accept) begin
            if (final_step) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule

/* rtl/char_lcd_expander_byte_sequencer_core.sv */
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                 | Payload
// request   | in        | i_valid / o_ready         | i_req_type, i_value, i_row, i_col
// result    | out       | o_valid / i_ready         | o_expander_byte, o_last_of_run
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Byte and cursor requests are pushed to the queue in the same cycle they are accepted;
// the back sends one expander byte per accepted output cycle, four per byte transfer and
// two for a lone nibble. A number keeps o_ready low through the shift-add-3 conversion,
// the leading-zero scan and the push of each digit, and gives four output bytes per digit.
// A four-entry job queue decouples front and back; a full queue also stalls the front.
// Reset loads the register defaults and empties the queue; no clearing pass.

module char_lcd_expander_byte_sequencer_core #(
    parameter int NUMBER_BITS = clebs_pkg::NUMBER_BITS_DEF,
    parameter int QUEUE_DEPTH = clebs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_value,
    input  logic        i_row,
    input  logic [7:0]  i_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_expander_byte,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    clebs_pkg::t_cfg r_cfg;
    clebs_pkg::t_job push_job, head_job;
    logic            push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backlight <= clebs_pkg::RST_BACKLIGHT;
            r_cfg.enable    <= clebs_pkg::RST_ENABLE;
            r_cfg.select    <= clebs_pkg::RST_SELECT;
            r_cfg.row0_addr <= clebs_pkg::RST_ROW0_ADDR;
            r_cfg.row1_addr <= clebs_pkg::RST_ROW1_ADDR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                clebs_pkg::CFG_BACKLIGHT: r_cfg.backlight <= i_cfg_data;
                clebs_pkg::CFG_ENABLE:    r_cfg.enable    <= i_cfg_data;
                clebs_pkg::CFG_SELECT:    r_cfg.select    <= i_cfg_data;
                clebs_pkg::CFG_ROW0_ADDR: r_cfg.row0_addr <= i_cfg_data;
                clebs_pkg::CFG_ROW1_ADDR: r_cfg.row1_addr <= i_cfg_data;
                default: ; // unknown index: drop
            endcase
        end
    end

    clebs_front #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    clebs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    clebs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job           (head_job),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_expander_byte (o_expander_byte),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
